// ===== rtl/core/jseu_pkg.sv =====
// Package for the JSON string escaper with UTF-8 sanitizing.
// Holds character codes, burst sizing and the hex digit helper.
// No dependencies; used by the top level and its checker.
`default_nettype none

package jseu_pkg;

   typedef logic [7:0] byte_type;

   // Longest burst one input beat can produce: three flushed marks plus a
   // six-byte \u00XX escape.
   localparam int unsigned BurstDepth = 9;
   localparam int unsigned BurstCntW  = $clog2(BurstDepth + 1);
   localparam int unsigned EscDepth   = 6;

   typedef logic [BurstCntW-1:0] burst_cnt_type;

   localparam byte_type ChQuote     = 8'h22;
   localparam byte_type ChBackslash = 8'h5C;
   localparam byte_type ChMark      = 8'h3F;  // '?'
   localparam byte_type ChU         = 8'h75;  // 'u'
   localparam byte_type ChZero      = 8'h30;  // '0'
   localparam byte_type ChLowA      = 8'h61;  // 'a'
   localparam byte_type ChSpace     = 8'h20;

   localparam logic [20:0] CpMax     = 21'h10FFFF;
   localparam logic [20:0] CpSurLow  = 21'h00D800;
   localparam logic [20:0] CpSurHigh = 21'h00DFFF;
   localparam logic [20:0] CpMin2    = 21'h000080;
   localparam logic [20:0] CpMin3    = 21'h000800;
   localparam logic [20:0] CpMin4    = 21'h010000;

   // Lowercase hex digit for one nibble.
   function automatic byte_type hex_char(input logic [3:0] nib);
      byte_type ch;
      if (nib < 4'd10) begin
         ch = ChZero + {4'b0, nib};
      end else begin
         ch = ChLowA + {4'b0, nib} - 8'd10;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/json_string_escape_utf8_sanitize.sv =====
// JSON string escaper with UTF-8 sanitizing, top level.
// Depends on jseu_pkg for character codes and the hex digit helper.
`default_nettype none

// Takes the raw bytes of a text string, one per req beat, and a closing beat
// with req_end_mark set, and emits the quoted JSON form one byte per rsp beat.
// The first beat of a string is preceded by an opening quote; quote and
// backslash get a backslash prefix; control bytes below 0x20 become \u00xx;
// valid 2..4 byte UTF-8 sequences are held until complete and passed
// through, while broken, overlong, surrogate or out-of-range sequences turn
// into one '?' per byte. rsp_run_last marks the final byte caused by a req
// beat, rsp_string_done marks the closing quote. A req beat that only extends
// a pending UTF-8 sequence produces no rsp beat.
// Pipeline: input register, then a burst buffer that the decode logic loads
// with every byte a beat produces (up to nine), then the rsp output register.
// With rsp_ready high, a beat that yields one byte passes at one beat per cycle;
// a beat yielding N bytes occupies the burst buffer until its last byte moves
// out, one byte per cycle through the output register while rsp_ready is high,
// and holds off req_ready for the next beat until then.
module json_string_escape_utf8_sanitize (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire jseu_pkg::byte_type req_text_byte,
   input  wire                 req_end_mark,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output jseu_pkg::byte_type  rsp_out_byte,
   output logic                rsp_run_last,
   output logic                rsp_string_done
);
   import jseu_pkg::*;

   // input register
   logic          a_valid_ff, a_valid_in;
   byte_type      a_byte_ff;
   logic          a_end_ff;

   // string and UTF-8 sequence state
   logic          open_ff, open_in;
   logic [1:0]    pcnt_ff, pcnt_in;
   logic [2:0]    elen_ff, elen_in;
   byte_type      pend_ff [3];
   byte_type      pend_in [3];

   // burst buffer: head byte at index 0, shifts down as bytes leave
   byte_type      b_bytes_ff [BurstDepth];
   byte_type      b_bytes_in [BurstDepth];
   burst_cnt_type b_cnt_ff, b_cnt_in;
   logic          b_done_ff, b_done_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   byte_type      rsp_byte_ff;
   logic          rsp_last_ff;
   logic          rsp_done_ff;

   // handshake glue
   logic          out_load;
   logic          b_free;
   logic          a_adv;

   // decode results
   byte_type      pre_byte;
   logic [1:0]    pre_len;
   byte_type      m_bytes [EscDepth];
   logic [2:0]    m_len;
   logic          m_done;
   byte_type      fill_bytes [BurstDepth];
   burst_cnt_type fill_cnt;

   assign out_load  = (b_cnt_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign b_free    = (b_cnt_ff == '0) ||
                      ((b_cnt_ff == burst_cnt_type'(1)) && out_load);
   assign a_adv     = a_valid_ff && b_free;
   assign req_ready = !a_valid_ff || a_adv;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_run_last    = rsp_last_ff;
   assign rsp_string_done = rsp_done_ff;

   // Decode the registered beat against the sequence state: a prefix of
   // identical bytes (opening quote or flushed marks) and a main segment.
   always_comb begin
      logic        cont;
      logic        state_bad;
      logic        flush;
      logic        fresh;
      logic [2:0]  lead_len;
      logic [20:0] cp;
      logic [20:0] cp_min;
      logic        cp_bad;
      logic [3:0]  rel;
      byte_type    c;

      c         = a_byte_ff;
      cont      = (c[7:6] == 2'b10);
      state_bad = (elen_ff < 3'd2) || (elen_ff > 3'd4) ||
                  ({1'b0, pcnt_ff} >= elen_ff);
      flush     = a_end_ff || ((pcnt_ff != 2'd0) && (!cont || state_bad));
      fresh     = !a_end_ff && ((pcnt_ff == 2'd0) || flush);

      lead_len = 3'd0;
      if (c[7:5] == 3'b110) begin
         lead_len = 3'd2;
      end else if (c[7:4] == 4'b1110) begin
         lead_len = 3'd3;
      end else if (c[7:3] == 5'b11110) begin
         lead_len = 3'd4;
      end

      case (elen_ff)
         3'd2: begin
            cp     = {10'b0, pend_ff[0][4:0], c[5:0]};
            cp_min = CpMin2;
         end
         3'd3: begin
            cp     = {5'b0, pend_ff[0][3:0], pend_ff[1][5:0], c[5:0]};
            cp_min = CpMin3;
         end
         default: begin
            cp     = {pend_ff[0][2:0], pend_ff[1][5:0], pend_ff[2][5:0], c[5:0]};
            cp_min = CpMin4;
         end
      endcase
      cp_bad = (cp < cp_min) || (cp > CpMax) ||
               ((cp >= CpSurLow) && (cp <= CpSurHigh));

      // prefix: opening quote, or the flushed pending bytes as marks
      if (!open_ff) begin
         pre_byte = ChQuote;
         pre_len  = 2'd1;
      end else begin
         pre_byte = ChMark;
         pre_len  = flush ? pcnt_ff : 2'd0;
      end

      for (int j = 0; j < EscDepth; j++) begin
         m_bytes[j] = '0;
      end
      m_len   = 3'd0;
      m_done  = 1'b0;
      open_in = open_ff;
      pcnt_in = pcnt_ff;
      elen_in = elen_ff;
      for (int j = 0; j < 3; j++) begin
         pend_in[j] = pend_ff[j];
      end

      if (a_adv) begin
         open_in = !a_end_ff;
         if (flush) begin
            pcnt_in = 2'd0;
            elen_in = 3'd0;
         end
      end

      if (a_end_ff) begin
         m_bytes[0] = ChQuote;
         m_len      = 3'd1;
         m_done     = 1'b1;
      end else if (fresh) begin
         if ((c == ChQuote) || (c == ChBackslash)) begin
            m_bytes[0] = ChBackslash;
            m_bytes[1] = c;
            m_len      = 3'd2;
         end else if (c < ChSpace) begin
            m_bytes[0] = ChBackslash;
            m_bytes[1] = ChU;
            m_bytes[2] = ChZero;
            m_bytes[3] = ChZero;
            m_bytes[4] = hex_char(c[7:4]);
            m_bytes[5] = hex_char(c[3:0]);
            m_len      = 3'd6;
         end else if (!c[7]) begin
            m_bytes[0] = c;
            m_len      = 3'd1;
         end else if (lead_len == 3'd0) begin
            m_bytes[0] = ChMark;
            m_len      = 3'd1;
         end else if (a_adv) begin
            // hold the lead byte, nothing to emit yet
            pend_in[0] = c;
            pcnt_in    = 2'd1;
            elen_in    = lead_len;
         end
      end else if (({1'b0, pcnt_ff} + 3'd1) < elen_ff) begin
         if (a_adv) begin
            pend_in[pcnt_ff] = c;
            pcnt_in          = pcnt_ff + 2'd1;
         end
      end else begin
         // sequence complete: pass it through or replace every byte
         for (int j = 0; j < 3; j++) begin
            if (3'(j) < elen_ff) begin
               if (cp_bad) begin
                  m_bytes[j] = ChMark;
               end else if (2'(j) == pcnt_ff) begin
                  m_bytes[j] = c;
               end else begin
                  m_bytes[j] = pend_ff[j];
               end
            end
         end
         // the fourth byte of a four-byte sequence is always the current one
         if (elen_ff == 3'd4) begin
            m_bytes[3] = cp_bad ? ChMark : c;
         end
         m_len = elen_ff;
         if (a_adv) begin
            pcnt_in = 2'd0;
            elen_in = 3'd0;
         end
      end

      // place prefix and main segment into burst slots
      for (int i = 0; i < BurstDepth; i++) begin
         rel = 4'(i) - {2'b0, pre_len};
         if (4'(i) < {2'b0, pre_len}) begin
            fill_bytes[i] = pre_byte;
         end else if (rel < 4'(EscDepth)) begin
            fill_bytes[i] = m_bytes[rel[2:0]];
         end else begin
            fill_bytes[i] = '0;
         end
      end
      fill_cnt = burst_cnt_type'({2'b0, pre_len}) + burst_cnt_type'({1'b0, m_len});
   end

   // Burst buffer: reload on a new beat, else shift one byte out.
   always_comb begin
      b_cnt_in  = b_cnt_ff;
      b_done_in = b_done_ff;
      for (int i = 0; i < BurstDepth; i++) begin
         b_bytes_in[i] = b_bytes_ff[i];
      end
      if (a_adv) begin
         b_cnt_in  = fill_cnt;
         b_done_in = m_done;
         for (int i = 0; i < BurstDepth; i++) begin
            b_bytes_in[i] = fill_bytes[i];
         end
      end else if (out_load) begin
         b_cnt_in = b_cnt_ff - burst_cnt_type'(1);
         for (int i = 0; i < BurstDepth - 1; i++) begin
            b_bytes_in[i] = b_bytes_ff[i+1];
         end
         b_bytes_in[BurstDepth-1] = '0;
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_ready) begin
         a_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         open_ff      <= 1'b0;
         pcnt_ff      <= 2'd0;
         elen_ff      <= 3'd0;
         b_cnt_ff     <= '0;
         b_done_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         open_ff      <= open_in;
         pcnt_ff      <= pcnt_in;
         elen_ff      <= elen_in;
         b_cnt_ff     <= b_cnt_in;
         b_done_ff    <= b_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: capture input beat, hold pending bytes, advance burst, load output
   always_ff @(posedge clock) begin
      if (req_ready) begin
         a_byte_ff <= req_text_byte;
         a_end_ff  <= req_end_mark;
      end
      for (int j = 0; j < 3; j++) begin
         pend_ff[j] <= pend_in[j];
      end
      for (int i = 0; i < BurstDepth; i++) begin
         b_bytes_ff[i] <= b_bytes_in[i];
      end
      if (out_load) begin
         rsp_byte_ff <= b_bytes_ff[0];
         rsp_last_ff <= (b_cnt_ff == burst_cnt_type'(1));
         rsp_done_ff <= (b_cnt_ff == burst_cnt_type'(1)) && b_done_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/jseu_checker.sv =====
// Port-level checker for the JSON string escaper, bound to the top level.
// Depends on jseu_pkg for the quote character code.
`default_nettype none

module jseu_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     rsp_valid,
   input wire                     rsp_ready,
   input wire jseu_pkg::byte_type rsp_out_byte,
   input wire                     rsp_run_last,
   input wire                     rsp_string_done
);
   import jseu_pkg::*;

   // the closing quote always ends the beat's run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_run_last)
      else $error("string_done without run_last");

   // the closing quote is a quote character
   a_done_is_quote: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_out_byte == ChQuote)
      else $error("string_done on a byte other than a quote");

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_run_last) && $stable(rsp_string_done))
      else $error("rsp beat changed while stalled");

   // reset drops the output
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind json_string_escape_utf8_sanitize jseu_checker u_jseu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_run_last    (rsp_run_last),
   .rsp_string_done (rsp_string_done)
);

`default_nettype wire
